// ----- rtl/core/alb_pkg.sv -----
// Package for the adaptive lamp brightness block: sizes, microcode format and program.
package alb_pkg;

  localparam int SAMPLE_DEPTH = 16;
  localparam int LAMP_COUNT   = 4;

  localparam int SMP_W  = 16;
  localparam int PTR_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W  = $clog2(SAMPLE_DEPTH * 65535 + 1);
  localparam int NUM_W  = SUM_W + 3;
  localparam int DEN_W  = $clog2(10 * SAMPLE_DEPTH + 1);
  localparam int DSH_W  = DEN_W + 6;
  localparam int LAMP_W = (LAMP_COUNT > 4) ? $clog2(LAMP_COUNT) : 2;
  localparam int MASK_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam int QBITS  = 7;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_CAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT      = 3'd4;

  localparam logic [7:0] OFFSET_RESET = 8'd128;
  localparam logic [7:0] WHITE_MAX    = 8'd128;
  // 28 - avg/10 never reaches the floor of 32, so amber is always the floor
  localparam logic [7:0] AMBER_LEVEL  = 8'd32;
  localparam logic [3:0] BLINK_LAST   = 4'd9;
  localparam logic [3:0] BLINK_ON_LIM = 4'd5;

  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_READ,
    OP_STORE,
    OP_SETUP,
    OP_CLAMP,
    OP_DIV,
    OP_EMIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_TICK,
    C_CLAMPED,
    C_CNT_NZ,
    C_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [STEP_W-1:0]  target;
  } ctl_t;

  localparam logic [STEP_W-1:0] ST_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] ST_READ  = 3'd1;
  localparam logic [STEP_W-1:0] ST_STORE = 3'd2;
  localparam logic [STEP_W-1:0] ST_SETUP = 3'd3;
  localparam logic [STEP_W-1:0] ST_CLAMP = 3'd4;
  localparam logic [STEP_W-1:0] ST_DIV   = 3'd5;
  localparam logic [STEP_W-1:0] ST_EMIT  = 3'd6;
  localparam logic [STEP_W-1:0] ST_NOP   = 3'd7;

  // control store: jump to target when cond holds, else step on
  function automatic ctl_t ucode(input logic [STEP_W-1:0] pc);
    ctl_t c;
    unique case (pc)
      ST_WAIT:  c = '{op: OP_WAIT,  cond: C_NO_IN,     target: ST_WAIT};
      ST_READ:  c = '{op: OP_READ,  cond: C_TICK,      target: ST_SETUP};
      ST_STORE: c = '{op: OP_STORE, cond: C_ALWAYS,    target: ST_WAIT};
      ST_SETUP: c = '{op: OP_SETUP, cond: C_NEVER,     target: ST_WAIT};
      ST_CLAMP: c = '{op: OP_CLAMP, cond: C_CLAMPED,   target: ST_EMIT};
      ST_DIV:   c = '{op: OP_DIV,   cond: C_CNT_NZ,    target: ST_DIV};
      ST_EMIT:  c = '{op: OP_EMIT,  cond: C_EMIT_MORE, target: ST_EMIT};
      ST_NOP:   c = '{op: OP_NOP,   cond: C_ALWAYS,    target: ST_WAIT};
      default:  c = '{op: OP_NOP,   cond: C_ALWAYS,    target: ST_WAIT};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/adaptive_lamp_brightness_top.sv -----
// Adaptive lamp brightness: microcoded sample averaging and per-lamp level output.
//
// A sample word (func 0) passes through accept, read of the overwritten ring
// entry from the sample memory, then sum/pointer update and write. An update
// tick (func 1) passes through accept, memory read slot, setup of numerator
// and denominator 10*n, clamp check, up to 7 restoring divide steps (skipped
// when the white level clamps), one lamp word per cycle while the output does
// not stall, and one closing step. The average uses the running sum and fill
// count, so no walk over the ring buffer is ever needed.
module adaptive_lamp_brightness_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [alb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alb_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [15:0]                     in_light_sample,
  input  logic [1:0]                      in_turn_request,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_lamp_index,
  output logic [7:0]                      out_white_level,
  output logic [6:0]                      out_red_level,
  output logic [7:0]                      out_amber_level,
  output logic                            out_last_lamp
);
  import alb_pkg::*;

  localparam logic signed [NUM_W-1:0] K1000 = NUM_W'(1000);
  localparam logic signed [NUM_W-1:0] K128  = NUM_W'(128);
  localparam logic signed [NUM_W-1:0] K5    = NUM_W'(5);
  localparam logic [LAMP_W-1:0]       LAMP_LAST = LAMP_W'(LAMP_COUNT - 1);

  // config
  logic [7:0]        offset_r;
  logic [MASK_W-1:0] front_r, turn_cap_r, left_r, right_r;

  // control
  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [LAMP_W-1:0] lamp_r, lamp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [3:0]        phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath
  logic              func_r;
  logic [SMP_W-1:0]  sample_r;
  logic [1:0]        turn_r;
  logic [SMP_W-1:0]  rd_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [7:0]        white_r;
  logic [1:0]        o_idx_r;
  logic [7:0]        o_white_r, o_amber_r;
  logic [6:0]        o_red_r;
  logic              o_last_r;

  logic [SMP_W-1:0]  mem [SAMPLE_DEPTH];

  ctl_t ctl;
  logic in_acc, out_acc, slot_free, full, jump;
  logic is_neg, is_high, trial_ok;
  logic [NUM_W-1:0] trial, lim;
  logic [FILL_W-1:0] n_v;
  logic [SUM_W-1:0]  s_v;
  logic signed [NUM_W-1:0] n_s, s_s, o_s, w10;
  logic [DEN_W-1:0] den_v;
  logic lamp_ok, front, side_match, show_amber, is_last;

  assign ctl       = ucode(pc_r);
  assign in_stall  = (ctl.op != OP_WAIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign full      = (fill_r == FILL_W'(SAMPLE_DEPTH));

  // arithmetic of the tick
  assign n_v   = (fill_r == '0) ? FILL_W'(1) : fill_r;
  assign s_v   = (fill_r == '0) ? '0 : sum_r;
  assign n_s   = $signed(NUM_W'(n_v));
  assign s_s   = $signed(NUM_W'(s_v));
  assign o_s   = $signed(NUM_W'(offset_r)) - K128;
  // 10n*white = 1000n - 2S + 5n(offset-128)
  assign w10   = n_s * K1000 - (s_s <<< 1) + n_s * o_s * K5;
  assign den_v = DEN_W'(n_v) * DEN_W'(10);

  assign lim      = NUM_W'({den_r, 7'b0});
  assign is_neg   = num_r[NUM_W-1];
  assign is_high  = !is_neg && (num_r >= lim);
  assign trial    = num_r - NUM_W'(dsh_r);
  assign trial_ok = !trial[NUM_W-1];

  // lamp decode
  assign lamp_ok    = ({1'b0, lamp_r} < (LAMP_W + 1)'(4));
  assign front      = lamp_ok && front_r[lamp_r[1:0]];
  assign side_match = (left_r[lamp_r[1:0]] && turn_r[0]) ||
                      (right_r[lamp_r[1:0]] && turn_r[1]);
  assign show_amber = lamp_ok && turn_cap_r[lamp_r[1:0]] && side_match &&
                      (phase_r < BLINK_ON_LIM);
  assign is_last    = (lamp_r == LAMP_LAST);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_IN:     jump = !in_acc;
      C_TICK:      jump = func_r;
      C_CLAMPED:   jump = is_neg || is_high;
      C_CNT_NZ:    jump = (cnt_r != '0);
      C_EMIT_MORE: jump = !(slot_free && is_last);
      default:     jump = 1'b0;
    endcase
    pc_nxt = jump ? ctl.target : pc_r + 1'b1;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    lamp_nxt      = lamp_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_acc;
    unique case (ctl.op)
      OP_STORE: begin
        sum_nxt  = sum_r - (full ? SUM_W'(rd_r) : '0) + SUM_W'(sample_r);
        fill_nxt = full ? fill_r : fill_r + 1'b1;
        wp_nxt   = (wp_r == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      OP_SETUP: begin
        phase_nxt = (phase_r == BLINK_LAST) ? '0 : phase_r + 1'b1;
      end
      OP_CLAMP: begin
        cnt_nxt = 3'(QBITS - 1);
      end
      OP_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          lamp_nxt      = is_last ? '0 : lamp_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_WAIT;
      cnt_r       <= '0;
      lamp_r      <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      offset_r    <= OFFSET_RESET;
      front_r     <= '0;
      turn_cap_r  <= '0;
      left_r      <= '0;
      right_r     <= '0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      lamp_r      <= lamp_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BRIGHTNESS: offset_r   <= cfg_data;
          CFG_FRONT:      front_r    <= cfg_data[MASK_W-1:0];
          CFG_TURN_CAP:   turn_cap_r <= cfg_data[MASK_W-1:0];
          CFG_LEFT:       left_r     <= cfg_data[MASK_W-1:0];
          CFG_RIGHT:      right_r    <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_func;
      sample_r <= in_light_sample;
      turn_r   <= in_turn_request;
    end
    unique case (ctl.op)
      OP_SETUP: begin
        num_r <= w10;
        den_r <= den_v;
      end
      OP_CLAMP: begin
        white_r <= is_high ? WHITE_MAX : '0;
        dsh_r   <= DSH_W'({den_r, 6'b0});
      end
      OP_DIV: begin
        // restoring divide, one quotient bit per step, MSB first
        if (trial_ok) num_r <= trial;
        white_r <= {white_r[6:0], trial_ok};
        dsh_r   <= dsh_r >> 1;
      end
      OP_EMIT: begin
        if (slot_free) begin
          o_idx_r   <= lamp_r[1:0];
          o_white_r <= front ? white_r : '0;
          o_red_r   <= (turn_r != 2'b00 || front) ? '0 : white_r[7:1];
          o_amber_r <= show_amber ? AMBER_LEVEL : '0;
          o_last_r  <= is_last;
        end
      end
      default: ;
    endcase
  end

  // sample ring buffer
  always_ff @(posedge clk) begin
    if (ctl.op == OP_STORE) mem[wp_r] <= sample_r;
    if (ctl.op == OP_READ)  rd_r <= mem[wp_r];
  end

  assign out_valid       = out_valid_r;
  assign out_lamp_index  = o_idx_r;
  assign out_white_level = o_white_r;
  assign out_red_level   = o_red_r;
  assign out_amber_level = o_amber_r;
  assign out_last_lamp   = o_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(SAMPLE_DEPTH))
    else $error("fill count beyond depth");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sum_r) <= 32'(fill_r) * 32'd65535)
    else $error("running sum exceeds what the stored samples allow");

  a_white_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EMIT) |-> (white_r <= WHITE_MAX))
    else $error("white level out of range at emit");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_lamp) |-> (lamp_r == '0))
    else $error("lamp counter not wrapped after final word");

endmodule

// ----- tb/adaptive_lamp_brightness_top_tb.sv -----
// Self-checking testbench for adaptive_lamp_brightness_top: directed table, then random phases.
module adaptive_lamp_brightness_top_tb;
  import alb_pkg::*;

  localparam logic       FUNC_SAMPLE = 1'b0;
  localparam logic       FUNC_TICK   = 1'b1;
  localparam logic [1:0] REQ_NONE    = 2'b00;
  localparam logic [1:0] REQ_LEFT    = 2'b01;
  localparam logic [1:0] REQ_RIGHT   = 2'b10;
  localparam logic [1:0] REQ_BOTH    = 2'b11;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_RIGHT + 3'd1;

  localparam int BLINK_PERIOD   = 10;
  localparam int BLINK_ON       = 5;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 34;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] lamp;
    logic [7:0] white;
    logic [6:0] red;
    logic [7:0] amber;
    logic       last;
  } lamp_word_t;

  typedef struct packed {
    logic       func;
    logic [15:0] sample;
    logic [1:0] turn;
    logic       typed;
    logic [7:0] white;
    logic [6:0] red;
    logic [7:0] amber;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = 1'b0;
  logic [15:0]          in_light_sample = '0;
  logic [1:0]           in_turn_request = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_lamp_index;
  logic [7:0]           out_white_level;
  logic [6:0]           out_red_level;
  logic [7:0]           out_amber_level;
  logic                 out_last_lamp;

  adaptive_lamp_brightness_top DUT (.*);

  always #5 clk = ~clk;

  // directed words: typed levels are the pre-gating white/red/amber
  dir_row_t dir_rows [24] = '{
    '{FUNC_TICK,   16'd0,     REQ_NONE,  1'b1, 8'd100, 7'd50, 8'd32},
    '{FUNC_TICK,   16'd0,     REQ_BOTH,  1'b1, 8'd100, 7'd50, 8'd32},
    '{FUNC_SAMPLE, 16'd0,     REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_TICK,   16'd0,     REQ_NONE,  1'b1, 8'd100, 7'd50, 8'd32},
    '{FUNC_SAMPLE, 16'hFFFF,  REQ_BOTH,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_TICK,   16'hFFFF,  REQ_LEFT,  1'b1, 8'd0,   7'd0,  8'd32},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_TICK,   16'd0,     REQ_RIGHT, 1'b0, 8'd0,   7'd0,  8'd0},
    // ring full: these two overwrite the 0 and the 65535 entries
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_SAMPLE, 16'd250,   REQ_NONE,  1'b0, 8'd0,   7'd0,  8'd0},
    '{FUNC_TICK,   16'd0,     REQ_NONE,  1'b1, 8'd50,  7'd25, 8'd32}
  };

  // predictor copy of settings and state
  logic [7:0]        trim_q;
  logic [3:0]        front_q, tcap_q, left_q, right_q;
  logic [SMP_W-1:0]  ring_q [SAMPLE_DEPTH];
  logic [PTR_W-1:0]  wptr_q;
  logic [FILL_W-1:0] fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic [3:0]        blink_q;

  lamp_word_t lamp_words_due [$];
  int         err_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 1;
  bit         gapless = 1'b0;
  logic [9:0] stall_cyc = '0;

  function automatic longint clamp_ratio(input longint num, input longint den,
                                         input longint lo, input longint hi);
    if (num < lo * den) return lo;
    if (num >= hi * den) return hi;
    return num / den;
  endfunction

  // advance the predictor by one word; a tick queues one word per lamp
  task automatic lamp_levels_update(input logic f, input logic [15:0] smp,
                                    input logic [1:0] turn, input logic typed,
                                    input logic [7:0] tw, input logic [6:0] tr,
                                    input logic [7:0] ta);
    longint     n, s, w10;
    logic [7:0] white, amber;
    logic [6:0] red;
    logic       on, front, side;
    lamp_word_t w;
    int         i;
    if (f == FUNC_SAMPLE) begin
      if (fill_q >= SAMPLE_DEPTH) sum_q = sum_q - ring_q[wptr_q];
      else fill_q = fill_q + 1'b1;
      ring_q[wptr_q] = smp;
      sum_q = sum_q + smp;
      wptr_q = wptr_q + 1'b1;
    end else begin
      blink_q = (blink_q == BLINK_PERIOD - 1) ? 4'd0 : blink_q + 4'd1;
      on = (blink_q < BLINK_ON);
      n = (fill_q == 0) ? 1 : fill_q;
      s = (fill_q == 0) ? 0 : sum_q;
      // 10n * white = 1000n - 2S + 5n(trim - 128)
      w10 = 1000 * n - 2 * s + 5 * n * (longint'(trim_q) - 128);
      white = 8'(clamp_ratio(w10, 10 * n, 0, 128));
      red = 7'(white >> 1);
      amber = 8'(clamp_ratio(280 * n - s, 10 * n, 32, 128));
      if (typed) begin
        white = tw;
        red = tr;
        amber = ta;
      end
      for (i = 0; i < LAMP_COUNT; i++) begin
        front = front_q[i];
        side = (left_q[i] && turn[0]) || (right_q[i] && turn[1]);
        w.lamp = 2'(i);
        w.white = front ? white : 8'd0;
        w.red = (turn != REQ_NONE || front) ? 7'd0 : red;
        w.amber = (tcap_q[i] && side && on) ? amber : 8'd0;
        w.last = (i == LAMP_COUNT - 1);
        lamp_words_due.push_back(w);
      end
    end
  endtask

  task automatic send_word(input logic f, input logic [15:0] smp, input logic [1:0] turn,
                           input logic typed, input logic [7:0] tw, input logic [6:0] tr,
                           input logic [7:0] ta);
    int gap;
    in_valid <= 1'b1;
    in_func <= f;
    in_light_sample <= smp;
    in_turn_request <= turn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lamp_levels_update(f, smp, turn, typed, tw, tr, ta);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gapless ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold the sender until every lamp word is out, then let a sample finish too
  task automatic drain_results();
    in_valid <= 1'b0;
    while (lamp_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_BRIGHTNESS: trim_q = data;
      CFG_FRONT:      front_q = data[3:0];
      CFG_TURN_CAP:   tcap_q = data[3:0];
      CFG_LEFT:       left_q = data[3:0];
      CFG_RIGHT:      right_q = data[3:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [7:0] trim, input logic [3:0] front,
                                input logic [3:0] tcap, input logic [3:0] left,
                                input logic [3:0] right, input logic [CFG_IDX_W-1:0] spare);
    cfg_put(spare, 8'($urandom));
    cfg_put(CFG_BRIGHTNESS, trim);
    cfg_put(CFG_FRONT, {4'd0, front});
    cfg_put(CFG_TURN_CAP, {4'd0, tcap});
    cfg_put(CFG_LEFT, {4'd0, left});
    cfg_put(CFG_RIGHT, {4'd0, right});
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    lamp_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (lamp_words_due.size() == 0) begin
        $error("lamp word with no expectation: lamp_index %0d", out_lamp_index);
        err_count++;
      end else begin
        want = lamp_words_due.pop_front();
        check_field("lamp_index", want.lamp, out_lamp_index);
        check_field("white_level", want.white, out_white_level);
        check_field("red_level", want.red, out_red_level);
        check_field("amber_level", want.amber, out_amber_level);
        check_field("last_lamp", want.last, out_last_lamp);
      end
    end
  end

  // receiver stall pattern: none, sparse random, periodic, heavy random
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (stall_cyc[2:0] < 3'd5);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int          p, k, pick;
    logic        f;
    logic [15:0] smp;
    logic [1:0]  turn;
    logic [7:0]  trim;
    logic [3:0]  front, tcap, left, right;

    trim_q = OFFSET_RESET;
    front_q = '0;
    tcap_q = '0;
    left_q = '0;
    right_q = '0;
    wptr_q = '0;
    fill_q = '0;
    sum_q = '0;
    blink_q = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_settings(OFFSET_RESET, 4'b0101, 4'b0111, 4'b0011, 4'b1100, CFG_SPARE);
    for (k = 0; k < $size(dir_rows); k++)
      send_word(dir_rows[k].func, dir_rows[k].sample, dir_rows[k].turn, dir_rows[k].typed,
                dir_rows[k].white, dir_rows[k].red, dir_rows[k].amber);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      gapless = (p % 3 == 2);
      trim = 8'($urandom);
      front = 4'($urandom);
      tcap = 4'($urandom);
      left = 4'($urandom);
      right = 4'($urandom);
      case (p)
        0: begin
          trim = 8'd0;
          {front, tcap, left, right} = 16'hFFFF;
        end
        1: begin
          trim = 8'd255;
          front = 4'hF;
          {tcap, left, right} = 12'h000;
        end
        2: begin
          trim = OFFSET_RESET;
          front = 4'h0;
        end
        default: ;
      endcase
      write_settings(trim, front, tcap, left, right, CFG_SPARE + 3'(p % 3));

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        f = ($urandom_range(0, 9) < 3) ? FUNC_TICK : FUNC_SAMPLE;
        pick = $urandom_range(0, 24);
        if (pick == 0) smp = 16'($urandom);
        else if (pick < 4) smp = 16'($urandom_range(0, 30));
        else smp = 16'($urandom_range(0, 900));
        turn = 2'($urandom);
        if ($urandom_range(0, 4) == 0) turn = REQ_NONE;
        send_word(f, smp, turn, 1'b0, 8'd0, 7'd0, 8'd0);
      end
    end

    drain_results();
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
